FILE: src/pcpg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcpg_pkg: shared types, constants and microcode for the curve point generator
// Holds the result item layout, the control word format, the sequencer
// program and the coordinate saturation helper.
// ----------------------------------------------------------------------------
package pcpg_pkg;

    localparam int MAX_POINTS_DEF  = 4096;
    localparam int T_FRAC_BITS_DEF = 16;

    localparam int CW        = 24;  // coordinate width
    localparam int COUNT_W   = 13;  // point_count field width
    localparam int MIN_STEPS = 48;
    localparam int PIX_SHIFT = 7;   // |2*span| in pixels is |span| >> 7 in raw units

    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

    localparam logic [1:0] STATUS_POINT   = 2'd0;
    localparam logic [1:0] STATUS_SUMMARY = 2'd1;
    localparam logic [1:0] STATUS_NONE    = 2'd2;

    localparam int UPC_W = 4;
    typedef logic [UPC_W-1:0] upc_t;

    typedef enum logic [3:0] {
        U_IDLE     = 4'd0,
        U_SPAN     = 4'd1,
        U_BOX      = 4'd2,
        U_EMIT     = 4'd3,
        U_NOSHAPE  = 4'd4,
        U_DIV_INIT = 4'd5,
        U_DIV_STEP = 4'd6,
        U_T_ROUND  = 4'd7,
        U_MUL_TX   = 4'd8,
        U_RND_X    = 4'd9,
        U_MUL_PT   = 4'd10,
        U_RND_P    = 4'd11,
        U_MUL_PY   = 4'd12,
        U_RND_Y    = 4'd13
    } uop_t;

    typedef enum logic [2:0] {
        C_NEXT     = 3'd0,
        C_JUMP     = 3'd1,
        C_DISPATCH = 3'd2,
        C_DIV_LOOP = 3'd3,
        C_POW_LOOP = 3'd4,
        C_OUT_WAIT = 3'd5
    } cond_t;

    typedef struct packed {
        uop_t  op;
        cond_t cond;
        upc_t  target;
    } uword_t;

    // program labels
    localparam upc_t L_IDLE     = 4'd0;
    localparam upc_t L_START    = 4'd1;
    localparam upc_t L_BOX      = 4'd2;
    localparam upc_t L_EMIT     = 4'd3;
    localparam upc_t L_NOSHAPE  = 4'd4;
    localparam upc_t L_POINT    = 4'd5;
    localparam upc_t L_DIV      = 4'd6;
    localparam upc_t L_T_ROUND  = 4'd7;
    localparam upc_t L_MUL_TX   = 4'd8;
    localparam upc_t L_RND_X    = 4'd9;
    localparam upc_t L_MUL_PT   = 4'd10;
    localparam upc_t L_RND_P    = 4'd11;
    localparam upc_t L_MUL_PY   = 4'd12;
    localparam upc_t L_RND_Y    = 4'd13;

    // status from the datapath that steers the sequencer
    typedef struct packed {
        logic req_valid;
        logic func;
        logic active;
        logic div_more;
        logic pow_more;
        logic out_busy;
    } flags_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [CW-1:0]    point_x;
        logic signed [CW-1:0]    point_y;
        logic signed [CW-1:0]    min_x;
        logic signed [CW-1:0]    min_y;
        logic signed [CW-1:0]    max_x;
        logic signed [CW-1:0]    max_y;
        logic [COUNT_W-1:0]      point_count;
        logic                    last;
    } res_t;

    function automatic uword_t ucode(input upc_t addr);
        uword_t w;
        case (addr)
            L_IDLE:    w = '{U_IDLE,     C_DISPATCH, L_IDLE};
            L_START:   w = '{U_SPAN,     C_NEXT,     L_IDLE};
            L_BOX:     w = '{U_BOX,      C_NEXT,     L_IDLE};
            L_EMIT:    w = '{U_EMIT,     C_OUT_WAIT, L_IDLE};
            L_NOSHAPE: w = '{U_NOSHAPE,  C_JUMP,     L_EMIT};
            L_POINT:   w = '{U_DIV_INIT, C_NEXT,     L_IDLE};
            L_DIV:     w = '{U_DIV_STEP, C_DIV_LOOP, L_DIV};
            L_T_ROUND: w = '{U_T_ROUND,  C_NEXT,     L_IDLE};
            L_MUL_TX:  w = '{U_MUL_TX,   C_NEXT,     L_IDLE};
            L_RND_X:   w = '{U_RND_X,    C_NEXT,     L_IDLE};
            L_MUL_PT:  w = '{U_MUL_PT,   C_NEXT,     L_IDLE};
            L_RND_P:   w = '{U_RND_P,    C_POW_LOOP, L_MUL_PT};
            L_MUL_PY:  w = '{U_MUL_PY,   C_NEXT,     L_IDLE};
            L_RND_Y:   w = '{U_RND_Y,    C_JUMP,     L_EMIT};
            default:   w = '{U_IDLE,     C_JUMP,     L_IDLE};
        endcase
        return w;
    endfunction

    // clamp a widened sum to the signed coordinate range
    function automatic logic signed [CW-1:0] sat24(input logic signed [CW+1:0] v);
        logic signed [CW+1:0] hi;
        logic signed [CW+1:0] lo;
        hi = (CW+2)'(COORD_MAX);
        lo = (CW+2)'(COORD_MIN);
        if (v > hi) begin
            return COORD_MAX;
        end
        else if (v < lo) begin
            return COORD_MIN;
        end
        return v[CW-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: src/pcpg_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcpg_ifs: request and response channels of the curve point generator
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pcpg_req_if;
    logic                           valid;
    logic                           ready;
    logic                           func;
    logic signed [pcpg_pkg::CW-1:0] origin_x;
    logic signed [pcpg_pkg::CW-1:0] origin_y;
    logic signed [pcpg_pkg::CW-1:0] end_x;
    logic signed [pcpg_pkg::CW-1:0] end_y;
    logic                           shift_key;
    logic                           control_key;

    modport source (
        output valid, func, origin_x, origin_y, end_x, end_y, shift_key, control_key,
        input  ready
    );
    modport sink (
        input  valid, func, origin_x, origin_y, end_x, end_y, shift_key, control_key,
        output ready
    );
endinterface

interface pcpg_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          status;
    logic signed [pcpg_pkg::CW-1:0]      point_x;
    logic signed [pcpg_pkg::CW-1:0]      point_y;
    logic signed [pcpg_pkg::CW-1:0]      min_x;
    logic signed [pcpg_pkg::CW-1:0]      min_y;
    logic signed [pcpg_pkg::CW-1:0]      max_x;
    logic signed [pcpg_pkg::CW-1:0]      max_y;
    logic [pcpg_pkg::COUNT_W-1:0]        point_count;
    logic                                last;

    modport source (
        output valid, status, point_x, point_y, min_x, min_y, max_x, max_y,
               point_count, last,
        input  ready
    );
    modport sink (
        input  valid, status, point_x, point_y, min_x, min_y, max_x, max_y,
               point_count, last,
        output ready
    );
endinterface
`default_nettype wire

FILE: src/pcpg_useq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcpg_useq: microprogram sequencer
// Steps through the control store and takes conditional jumps on datapath flags.
// ----------------------------------------------------------------------------
module pcpg_useq (
    input  logic             clk,
    input  logic             rst_n,
    input  pcpg_pkg::flags_t flags,
    output pcpg_pkg::uword_t uw
);

    pcpg_pkg::upc_t upc_reg;
    pcpg_pkg::upc_t upc_next;
    pcpg_pkg::upc_t upc_inc;

    assign uw      = pcpg_pkg::ucode(upc_reg);
    assign upc_inc = upc_reg + pcpg_pkg::UPC_W'(1);

    always_comb
    begin
        case (uw.cond)
            pcpg_pkg::C_NEXT:     upc_next = upc_inc;
            pcpg_pkg::C_JUMP:     upc_next = uw.target;
            pcpg_pkg::C_DISPATCH:
            begin
                if (!flags.req_valid) begin
                    upc_next = upc_reg;
                end
                else if (!flags.func) begin
                    upc_next = pcpg_pkg::L_START;
                end
                else if (flags.active) begin
                    upc_next = pcpg_pkg::L_POINT;
                end
                else begin
                    upc_next = pcpg_pkg::L_NOSHAPE;
                end
            end
            pcpg_pkg::C_DIV_LOOP: upc_next = flags.div_more ? uw.target : upc_inc;
            pcpg_pkg::C_POW_LOOP: upc_next = flags.pow_more ? uw.target : upc_inc;
            pcpg_pkg::C_OUT_WAIT: upc_next = flags.out_busy ? upc_reg : uw.target;
            default:              upc_next = pcpg_pkg::L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            upc_reg <= pcpg_pkg::L_IDLE;
        end
        else begin
            upc_reg <= upc_next;
        end
    end

endmodule
`default_nettype wire

FILE: src/pcpg_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcpg_dpath: shape state, bit-serial divider, shared multiplier, output stage
// Executes one micro-operation per cycle as selected by the sequencer.
// ----------------------------------------------------------------------------
module pcpg_dpath #(
    parameter int MAX_POINTS  = pcpg_pkg::MAX_POINTS_DEF,
    parameter int T_FRAC_BITS = pcpg_pkg::T_FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pcpg_pkg::uop_t    op,
    output pcpg_pkg::flags_t  flags,
    pcpg_req_if.sink          req,
    pcpg_rsp_if.source        rsp
);

    localparam int CW = pcpg_pkg::CW;
    localparam int SW = $clog2(MAX_POINTS + 1);          // step counter width
    localparam int TW = T_FRAC_BITS + 2;                 // signed t and t^k
    localparam int MW = (TW > CW) ? TW : CW;             // wide multiplier operand
    localparam int PW = TW + MW;                         // product width
    localparam int NRW = CW - pcpg_pkg::PIX_SHIFT;       // raw step estimate width
    localparam int NW = (SW > NRW) ? SW : NRW;
    localparam int KW = $clog2(T_FRAC_BITS + 1);
    localparam logic [PW-1:0] HALF = PW'(1) << (T_FRAC_BITS - 1);

    typedef struct packed {
        logic signed [CW-1:0] origin_x;
        logic signed [CW-1:0] origin_y;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
        logic                 shift_key;
        logic                 control_key;
    } start_t;

    // control state
    logic              active_reg, active_next;
    logic [SW-1:0]     step_reg, step_next;
    logic [SW-1:0]     total_reg, total_next;
    logic [1:0]        pmode_reg, pmode_next;
    logic [KW-1:0]     cnt_reg, cnt_next;
    logic [2:0]        pcnt_reg, pcnt_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    start_t                 start_reg, start_next;
    logic signed [CW-1:0]   org_x_reg, org_x_next;
    logic signed [CW-1:0]   org_y_reg, org_y_next;
    logic signed [CW-1:0]   span_x_reg, span_x_next;
    logic signed [CW-1:0]   span_y_reg, span_y_next;
    logic [SW:0]            rem_reg, rem_next;
    logic [T_FRAC_BITS:0]   quo_reg, quo_next;
    logic                   tneg_reg, tneg_next;
    logic signed [TW-1:0]   t_reg, t_next;
    logic signed [TW-1:0]   p_reg, p_next;
    logic signed [PW-1:0]   prod_reg, prod_next;
    pcpg_pkg::res_t         res_reg, res_next;
    pcpg_pkg::res_t         out_reg, out_next;

    // datapath terms
    logic                   accept;
    logic                   out_busy;
    logic                   emit;
    logic signed [CW+1:0]   span_x_w, span_y_w;
    logic signed [CW-1:0]   bx0, bx1, by0, by1;
    logic [CW:0]            smag;
    logic [NW-1:0]          ncmp;
    logic [SW-1:0]          nsel;
    logic signed [SW+1:0]   dstep;
    logic [SW+1:0]          dmag;
    logic [SW:0]            nwide;
    logic                   ge;
    logic [SW:0]            rdiff;
    logic                   rup;
    logic [TW-1:0]          tmag;
    logic signed [TW-1:0]   tval;
    logic signed [TW-1:0]   ma;
    logic signed [MW-1:0]   mb;
    logic signed [PW-1:0]   rsum;
    logic signed [PW-1:0]   rq;
    logic signed [CW:0]     off;
    logic signed [CW-1:0]   px, py;

    assign req.ready = (op == pcpg_pkg::U_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_busy  = out_valid_reg && !rsp.ready;
    assign emit      = (op == pcpg_pkg::U_EMIT) && !out_busy;

    assign flags.req_valid = req.valid;
    assign flags.func      = req.func;
    assign flags.active    = active_reg;
    assign flags.div_more  = (cnt_reg != '0);
    assign flags.pow_more  = (pcnt_reg != 3'd1);
    assign flags.out_busy  = out_busy;

    // start: span and bounding box
    assign span_x_w = (CW+2)'(start_reg.end_x) - (CW+2)'(start_reg.origin_x);
    assign span_y_w = (CW+2)'(start_reg.end_y) - (CW+2)'(start_reg.origin_y);
    assign bx0 = pcpg_pkg::sat24((CW+2)'(org_x_reg) - (CW+2)'(span_x_reg));
    assign bx1 = pcpg_pkg::sat24((CW+2)'(org_x_reg) + (CW+2)'(span_x_reg));
    assign by0 = pmode_reg[0] ? pcpg_pkg::sat24((CW+2)'(org_y_reg) - (CW+2)'(span_y_reg))
                              : org_y_reg;
    assign by1 = pcpg_pkg::sat24((CW+2)'(org_y_reg) + (CW+2)'(span_y_reg));

    assign smag = span_x_reg[CW-1] ? (CW+1)'(-(CW+1)'(span_x_reg)) : (CW+1)'(span_x_reg);
    assign ncmp = NW'(smag[CW-1:pcpg_pkg::PIX_SHIFT]);

    always_comb
    begin
        if (ncmp < NW'(pcpg_pkg::MIN_STEPS)) begin
            nsel = SW'(pcpg_pkg::MIN_STEPS);
        end
        else if (ncmp > NW'(MAX_POINTS)) begin
            nsel = SW'(MAX_POINTS);
        end
        else begin
            nsel = ncmp[SW-1:0];
        end
    end

    // t = round((2j - n) / n), one quotient bit per cycle
    assign dstep = $signed({1'b0, step_reg, 1'b0}) - $signed({2'b00, total_reg});
    assign dmag  = dstep[SW+1] ? (SW+2)'(-dstep) : (SW+2)'(dstep);
    assign nwide = {1'b0, total_reg};
    assign ge    = (rem_reg >= nwide);
    assign rdiff = ge ? (rem_reg - nwide) : rem_reg;
    // rem_reg holds twice the final remainder: round up when 2r >= n + (n odd)
    assign rup   = (rem_reg >= (nwide + (SW+1)'(total_reg[0])));
    assign tmag  = {1'b0, quo_reg} + TW'(rup);
    assign tval  = tneg_reg ? -$signed(tmag) : $signed(tmag);

    // shared multiplier and round-half-away rescale
    assign ma = (op == pcpg_pkg::U_MUL_TX) ? t_reg : p_reg;

    always_comb
    begin
        case (op)
            pcpg_pkg::U_MUL_TX: mb = MW'(span_x_reg);
            pcpg_pkg::U_MUL_PT: mb = MW'(t_reg);
            default:            mb = MW'(span_y_reg);
        endcase
    end

    assign rsum = prod_reg + $signed(HALF) - $signed(PW'(prod_reg[PW-1]));
    assign rq   = rsum >>> T_FRAC_BITS;
    assign off  = rq[CW:0];
    assign px   = pcpg_pkg::sat24((CW+2)'(org_x_reg) + (CW+2)'(off));
    assign py   = pcpg_pkg::sat24((CW+2)'(org_y_reg) + (CW+2)'(off));

    always_comb
    begin
        active_next = active_reg;
        step_next   = step_reg;
        total_next  = total_reg;
        pmode_next  = pmode_reg;
        cnt_next    = cnt_reg;
        pcnt_next   = pcnt_reg;
        start_next  = start_reg;
        org_x_next  = org_x_reg;
        org_y_next  = org_y_reg;
        span_x_next = span_x_reg;
        span_y_next = span_y_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        tneg_next   = tneg_reg;
        t_next      = t_reg;
        p_next      = p_reg;
        prod_next   = prod_reg;
        res_next    = res_reg;

        case (op)
            pcpg_pkg::U_IDLE:
            begin
                if (accept) begin
                    start_next.origin_x    = req.origin_x;
                    start_next.origin_y    = req.origin_y;
                    start_next.end_x       = req.end_x;
                    start_next.end_y       = req.end_y;
                    start_next.shift_key   = req.shift_key;
                    start_next.control_key = req.control_key;
                end
            end
            pcpg_pkg::U_SPAN:
            begin
                org_x_next  = start_reg.origin_x;
                org_y_next  = start_reg.origin_y;
                span_x_next = pcpg_pkg::sat24(span_x_w);
                span_y_next = pcpg_pkg::sat24(span_y_w);
                pmode_next  = {start_reg.shift_key, start_reg.control_key};
                step_next   = '0;
                active_next = 1'b1;
            end
            pcpg_pkg::U_BOX:
            begin
                total_next           = nsel;
                res_next             = '0;
                res_next.status      = pcpg_pkg::STATUS_SUMMARY;
                res_next.min_x       = (bx0 < bx1) ? bx0 : bx1;
                res_next.max_x       = (bx0 > bx1) ? bx0 : bx1;
                res_next.min_y       = (by0 < by1) ? by0 : by1;
                res_next.max_y       = (by0 > by1) ? by0 : by1;
                res_next.point_count = pcpg_pkg::COUNT_W'(nsel);
            end
            pcpg_pkg::U_NOSHAPE:
            begin
                res_next        = '0;
                res_next.status = pcpg_pkg::STATUS_NONE;
            end
            pcpg_pkg::U_DIV_INIT:
            begin
                rem_next  = dmag[SW:0];
                tneg_next = dstep[SW+1];
                quo_next  = '0;
                cnt_next  = KW'(T_FRAC_BITS);
                pcnt_next = {1'b0, pmode_reg} + 3'd1;
            end
            pcpg_pkg::U_DIV_STEP:
            begin
                quo_next = {quo_reg[T_FRAC_BITS-1:0], ge};
                rem_next = {rdiff[SW-1:0], 1'b0};
                cnt_next = cnt_reg - KW'(1);
            end
            pcpg_pkg::U_T_ROUND:
            begin
                t_next = tval;
                p_next = tval;
            end
            pcpg_pkg::U_MUL_TX,
            pcpg_pkg::U_MUL_PT,
            pcpg_pkg::U_MUL_PY:
            begin
                prod_next = ma * mb;
            end
            pcpg_pkg::U_RND_X:
            begin
                res_next         = '0;
                res_next.point_x = px;
            end
            pcpg_pkg::U_RND_P:
            begin
                p_next    = rq[TW-1:0];
                pcnt_next = pcnt_reg - 3'd1;
            end
            pcpg_pkg::U_RND_Y:
            begin
                res_next.status      = pcpg_pkg::STATUS_POINT;
                res_next.point_y     = py;
                res_next.point_count = pcpg_pkg::COUNT_W'(total_reg);
                res_next.last        = (step_reg >= total_reg);
                if (step_reg >= total_reg) begin
                    active_next = 1'b0;
                end
                else begin
                    step_next = step_reg + SW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // output register: load on emit, drop when taken
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_next       = res_reg;
            out_valid_next = 1'b1;
        end
        else if (rsp.ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            active_reg    <= 1'b0;
            step_reg      <= '0;
            total_reg     <= '0;
            pmode_reg     <= '0;
            cnt_reg       <= '0;
            pcnt_reg      <= 3'd1;
            out_valid_reg <= 1'b0;
        end
        else begin
            active_reg    <= active_next;
            step_reg      <= step_next;
            total_reg     <= total_next;
            pmode_reg     <= pmode_next;
            cnt_reg       <= cnt_next;
            pcnt_reg      <= pcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg  <= start_next;
        org_x_reg  <= org_x_next;
        org_y_reg  <= org_y_next;
        span_x_reg <= span_x_next;
        span_y_reg <= span_y_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        tneg_reg   <= tneg_next;
        t_reg      <= t_next;
        p_reg      <= p_next;
        prod_reg   <= prod_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_reg.status;
    assign rsp.point_x     = out_reg.point_x;
    assign rsp.point_y     = out_reg.point_y;
    assign rsp.min_x       = out_reg.min_x;
    assign rsp.min_y       = out_reg.min_y;
    assign rsp.max_x       = out_reg.max_x;
    assign rsp.max_y       = out_reg.max_y;
    assign rsp.point_count = out_reg.point_count;
    assign rsp.last        = out_reg.last;

    a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(op == pcpg_pkg::U_EMIT))
        else $error("output valid rose outside an emit step");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (step_reg <= total_reg))
        else $error("step index ran past the step count");

    a_count_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && (op != pcpg_pkg::U_SPAN) && (op != pcpg_pkg::U_BOX))
        |-> (total_reg >= SW'(pcpg_pkg::MIN_STEPS)))
        else $error("active shape with step count below the minimum");

    a_pow_count: assert property (@(posedge clk) disable iff (!rst_n)
        (op == pcpg_pkg::U_MUL_PT) |-> ((pcnt_reg != 3'd0) && (pcnt_reg <= 3'd4)))
        else $error("power loop counter out of range");

    a_last_ends_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && res_reg.last) |-> !active_reg)
        else $error("final point emitted while shape still active");

endmodule
`default_nettype wire

FILE: src/polynomial_curve_point_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// polynomial_curve_point_generator: power-curve tessellator for a drawing tool
// Start items define a shape and return its bounding box and step count;
// next items return the curve points one by one, or a no-shape answer.
// ----------------------------------------------------------------------------
// A start item (func 0) runs the span step, the box step and the emit step; a
// next item with no active shape runs the no-shape step and the emit step. A
// curve point of power k is formed by the bit-serial divider that forms t, one
// quotient bit per cycle, and by the single shared multiplier, which spends a
// multiply step and a round step on t*span_x, on each of the k-1 factors of
// t^k and on t^k*span_y. The block works on one item at a time: a new item is
// accepted once the microprogram is back at its idle step, which may be while
// the previous result still sits in the output register; the emit step holds
// only when that register is still full and not being taken. Coordinates are
// signed fixed point with 8 fraction bits and saturate at the 24-bit range; t
// and its powers carry T_FRAC_BITS fraction bits and every rescale rounds to
// nearest, ties away from zero. The step count saturates at MAX_POINTS and is
// reported in the 13-bit point_count field.
// ----------------------------------------------------------------------------
module polynomial_curve_point_generator #(
    parameter int MAX_POINTS  = pcpg_pkg::MAX_POINTS_DEF,
    parameter int T_FRAC_BITS = pcpg_pkg::T_FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pcpg_req_if.sink    req,
    pcpg_rsp_if.source  rsp
);

    // control word from the sequencer, status flags back from the datapath
    pcpg_pkg::uword_t uw;
    pcpg_pkg::flags_t flags;

    // microprogram counter and control store
    pcpg_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .uw    (uw)
    );

    // shape state, divider, multiplier and output register
    pcpg_dpath #(
        .MAX_POINTS  (MAX_POINTS),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (uw.op),
        .flags (flags),
        .req   (req),
        .rsp   (rsp)
    );

endmodule
`default_nettype wire

FILE: tb/tb_polynomial_curve_point_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polynomial_curve_point_generator: self-checking bench for the curve tessellator
// Drives start and next items through the request channel and checks every
// shape summary, curve point and no-shape answer field by field against a
// hand-written answer or a cycle-free predictor of the power curve. Random idling
// is applied on both channels, with one long output hold and drain pauses on the input side.
// ----------------------------------------------------------------------------
module tb_polynomial_curve_point_generator;

    import pcpg_pkg::*;

    localparam int     MAX_PTS        = MAX_POINTS_DEF;
    localparam int     T_FRAC         = T_FRAC_BITS_DEF;
    localparam longint T_ONE          = longint'(1) << T_FRAC;
    localparam longint C_HI           = 64'sd8388607;
    localparam longint C_LO           = -64'sd8388608;
    localparam int     N_RANDOM       = 1030;
    localparam int     LONG_HOLD      = 300;
    localparam int     WATCHDOG_LIMIT = 3000;
    localparam int     DRAIN_CYCLES   = 80;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_NEXT  = 1'b1;

    typedef struct packed {
        logic                 func;
        logic signed [CW-1:0] origin_x;
        logic signed [CW-1:0] origin_y;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
        logic                 shift_key;
        logic                 control_key;
    } req_item_t;

    // one row of the directed table; known rows carry a hand-written answer
    typedef struct {
        req_item_t item;
        bit        known;
        res_t      want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    pcpg_req_if req_ch ();
    pcpg_rsp_if rsp_ch ();

    polynomial_curve_point_generator #(
        .MAX_POINTS (MAX_PTS),
        .T_FRAC_BITS(T_FRAC)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    // shadow of the shape held inside the block
    logic signed [CW-1:0] shape_org_x;
    logic signed [CW-1:0] shape_org_y;
    logic signed [CW-1:0] shape_span_x;
    logic signed [CW-1:0] shape_span_y;
    logic [1:0]           shape_power;
    logic [COUNT_W-1:0]   shape_steps;
    logic [COUNT_W-1:0]   shape_index;
    bit                   shape_live;

    res_t curve_results_due[$];

    int  errors      = 0;
    int  items_sent  = 0;
    int  n_summary   = 0;
    int  n_points    = 0;
    int  n_curves    = 0;
    int  n_none      = 0;
    int  hold_asked  = 0;
    bit  calm        = 1'b0;
    int  quiet       = 0;

    // ------------------------------------------------------------------------
    // arithmetic helpers of the predictor
    // ------------------------------------------------------------------------

    // divide and round to nearest, ties away from zero; den is positive
    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint clamp24(input longint v);
        if (v > C_HI) begin
            return C_HI;
        end
        if (v < C_LO) begin
            return C_LO;
        end
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // predictor: advance the shadow shape by one item and return its answer
    // ------------------------------------------------------------------------
    function automatic res_t compute_curve_result(input req_item_t it);
        res_t   r;
        longint sx;
        longint sy;
        longint mag;
        longint n;
        longint x0;
        longint x1;
        longint y0;
        longint y1;
        longint j;
        longint t;
        longint p;
        int     k;
        r = '0;
        if (it.func == FUNC_START) begin
            // latch the new shape; any old one is dropped
            sx  = clamp24(longint'(it.end_x) - longint'(it.origin_x));
            sy  = clamp24(longint'(it.end_y) - longint'(it.origin_y));
            shape_org_x  = it.origin_x;
            shape_org_y  = it.origin_y;
            shape_span_x = CW'(sx);
            shape_span_y = CW'(sy);
            shape_power  = {it.shift_key, it.control_key};
            mag = (sx < 0) ? -sx : sx;
            n   = mag >> PIX_SHIFT;
            if (n < MIN_STEPS) begin
                n = MIN_STEPS;
            end
            if (n > MAX_PTS) begin
                n = MAX_PTS;
            end
            shape_steps = COUNT_W'(n);
            shape_index = '0;
            shape_live  = 1'b1;
            // x spans both sides of the vertex; y only one side for even powers
            x0 = clamp24(longint'(it.origin_x) - sx);
            x1 = clamp24(longint'(it.origin_x) + sx);
            y0 = shape_power[0] ? clamp24(longint'(it.origin_y) - sy) : longint'(it.origin_y);
            y1 = clamp24(longint'(it.origin_y) + sy);
            r.status      = STATUS_SUMMARY;
            r.min_x       = CW'((x0 < x1) ? x0 : x1);
            r.max_x       = CW'((x0 > x1) ? x0 : x1);
            r.min_y       = CW'((y0 < y1) ? y0 : y1);
            r.max_y       = CW'((y0 > y1) ? y0 : y1);
            r.point_count = shape_steps;
        end
        else if (!shape_live) begin
            r.status = STATUS_NONE;
        end
        else begin
            n = longint'(shape_steps);
            j = longint'(shape_index);
            t = round_div((2 * j - n) * T_ONE, n);
            p = t;
            k = 2 + int'(shape_power);
            for (int e = 1; e < k; e++) begin
                p = round_div(p * t, T_ONE);
            end
            r.status      = STATUS_POINT;
            r.point_x     = CW'(clamp24(longint'(shape_org_x)
                                        + round_div(t * longint'(shape_span_x), T_ONE)));
            r.point_y     = CW'(clamp24(longint'(shape_org_y)
                                        + round_div(p * longint'(shape_span_y), T_ONE)));
            r.point_count = shape_steps;
            if (shape_index >= shape_steps) begin
                r.last     = 1'b1;
                shape_live = 1'b0;
            end
            else begin
                shape_index = shape_index + 1'b1;
            end
        end
        return r;
    endfunction

    // a next item; the coordinate and key fields are don't-care, so randomize them
    function automatic req_item_t random_next_item();
        req_item_t it;
        it.func        = FUNC_NEXT;
        it.origin_x    = CW'($urandom);
        it.origin_y    = CW'($urandom);
        it.end_x       = CW'($urandom);
        it.end_y       = CW'($urandom);
        it.shift_key   = 1'($urandom);
        it.control_key = 1'($urandom);
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // offer one item, optionally after an idle burst; record its answer on accept
    task automatic offer_item(input req_item_t it, input bit known, input res_t want);
        res_t calc;
        if (!calm && $urandom_range(7, 0) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(15, 1)) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.func        <= it.func;
        req_ch.origin_x    <= it.origin_x;
        req_ch.origin_y    <= it.origin_y;
        req_ch.end_x       <= it.end_x;
        req_ch.end_y       <= it.end_y;
        req_ch.shift_key   <= it.shift_key;
        req_ch.control_key <= it.control_key;
        do begin
            @(posedge clk);
        end while (req_ch.ready !== 1'b1);
        calc = compute_curve_result(it);
        curve_results_due.push_back(known ? want : calc);
        items_sent++;
    endtask

    // drop valid and hold the input until every answer is back
    task automatic wait_all_results();
        req_ch.valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (curve_results_due.size() != 0);
    endtask

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // response side: random ready bursts, one long hold on request, none when calm
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int burst;
        int hold_taken;
        burst      = 0;
        hold_taken = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_taken < hold_asked) begin
                // hold off long enough for the block to fill and stall its input
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_taken++;
                rsp_ch.ready <= 1'b1;
            end
            else if (burst > 0) begin
                rsp_ch.ready <= 1'b0;
                burst--;
            end
            else if (!calm && $urandom_range(11, 0) == 0) begin
                rsp_ch.ready <= 1'b0;
                burst = $urandom_range(15, 1) - 1;
            end
            else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // checker: compare each accepted result with the oldest expectation
    // ------------------------------------------------------------------------
    initial begin : result_check
        res_t got;
        res_t want;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
                got.status      = rsp_ch.status;
                got.point_x     = rsp_ch.point_x;
                got.point_y     = rsp_ch.point_y;
                got.min_x       = rsp_ch.min_x;
                got.min_y       = rsp_ch.min_y;
                got.max_x       = rsp_ch.max_x;
                got.max_y       = rsp_ch.max_y;
                got.point_count = rsp_ch.point_count;
                got.last        = rsp_ch.last;
                if (curve_results_due.size() == 0) begin
                    $display("%0t: result with nothing expected: expected none, actual status %0d",
                             $time, got.status);
                    errors++;
                end
                else begin
                    want = curve_results_due.pop_front();
                    compare_field("status",      want.status,      got.status);
                    compare_field("point_x",     want.point_x,     got.point_x);
                    compare_field("point_y",     want.point_y,     got.point_y);
                    compare_field("min_x",       want.min_x,       got.min_x);
                    compare_field("min_y",       want.min_y,       got.min_y);
                    compare_field("max_x",       want.max_x,       got.max_x);
                    compare_field("max_y",       want.max_y,       got.max_y);
                    compare_field("point_count", want.point_count, got.point_count);
                    compare_field("last",        want.last,        got.last);
                    case (want.status)
                        STATUS_SUMMARY: n_summary++;
                        STATUS_POINT:   n_points++;
                        default:        n_none++;
                    endcase
                    if (want.last) begin
                        n_curves++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: end the run when neither channel moves for too long
    // ------------------------------------------------------------------------
    initial begin : watchdog
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
                || (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
                quiet = 0;
            end
            else begin
                quiet++;
            end
        end
        $display("%0t: watchdog expired, %0d results still due", $time,
                 curve_results_due.size());
        $display("tb_polynomial_curve_point_generator: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        dir_row_t  dir_tab[$];
        req_item_t it;
        longint    ox;
        longint    oy;
        longint    dx;
        longint    dy;
        int        pick;
        int        pts;
        int        n_dir;

        // drive every input to a known value from time zero
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.func        = FUNC_START;
        req_ch.origin_x    = '0;
        req_ch.origin_y    = '0;
        req_ch.end_x       = '0;
        req_ch.end_y       = '0;
        req_ch.shift_key   = 1'b0;
        req_ch.control_key = 1'b0;
        shape_org_x  = '0;
        shape_org_y  = '0;
        shape_span_x = '0;
        shape_span_y = '0;
        shape_power  = '0;
        shape_steps  = '0;
        shape_index  = '0;
        shape_live   = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: known answers where they follow at a glance
        // next right after reset: no shape yet, all other fields zero
        dir_tab.push_back('{'{FUNC_NEXT, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0},
                            1'b1, '{STATUS_NONE, '0, '0, '0, '0, '0, '0, '0, 1'b0}});
        // empty span: step count falls back to the floor, box collapses
        dir_tab.push_back('{'{FUNC_START, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0},
                            1'b1, '{STATUS_SUMMARY, '0, '0, '0, '0, '0, '0, 13'd48, 1'b0}});
        dir_tab.push_back('{'{FUNC_NEXT, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0},
                            1'b1, '{STATUS_POINT, '0, '0, '0, '0, '0, '0, 13'd48, 1'b0}});
        // full-range span, fifth power: restart, span and count saturate
        dir_tab.push_back('{'{FUNC_START, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1, 1'b1},
                            1'b1, '{STATUS_SUMMARY, '0, '0, COORD_MIN, COORD_MIN,
                                    -24'sd1, -24'sd1, 13'd4096, 1'b0}});
        dir_tab.push_back('{'{FUNC_NEXT, -24'sd1, -24'sd1, -24'sd1, -24'sd1, 1'b1, 1'b1},
                            1'b1, '{STATUS_POINT, COORD_MIN, COORD_MIN, '0, '0, '0, '0,
                                    13'd4096, 1'b0}});
        // reversed full span, square: even power keeps y on one side
        dir_tab.push_back('{'{FUNC_START, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 1'b0, 1'b0},
                            1'b1, '{STATUS_SUMMARY, '0, '0, -24'sd1, -24'sd1,
                                    COORD_MAX, COORD_MAX, 13'd4096, 1'b0}});
        dir_tab.push_back('{'{FUNC_NEXT, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0},
                            1'b1, '{STATUS_POINT, COORD_MAX, -24'sd1, '0, '0, '0, '0,
                                    13'd4096, 1'b0}});
        // cube with a step count between the floor and the ceiling
        dir_tab.push_back('{'{FUNC_START, 24'sd1000, -24'sd2000, 24'sd13800, 24'sd3000,
                              1'b0, 1'b1}, 1'b0, '0});
        dir_tab.push_back('{random_next_item(), 1'b0, '0});
        dir_tab.push_back('{random_next_item(), 1'b0, '0});
        // fourth power, negative span_x
        dir_tab.push_back('{'{FUNC_START, 24'sd1193046, -24'sd300000, 24'sd1185361, 24'sd600000,
                              1'b1, 1'b0}, 1'b0, '0});
        dir_tab.push_back('{random_next_item(), 1'b0, '0});
        dir_tab.push_back('{random_next_item(), 1'b0, '0});
        dir_tab.push_back('{random_next_item(), 1'b0, '0});
        // fifth power with a tall negative span_y
        dir_tab.push_back('{'{FUNC_START, -24'sd5000, 24'sd7000, 24'sd1000, -24'sd293000,
                              1'b1, 1'b1}, 1'b0, '0});
        dir_tab.push_back('{random_next_item(), 1'b0, '0});
        dir_tab.push_back('{random_next_item(), 1'b0, '0});
        // span_y saturates on the negative side
        dir_tab.push_back('{'{FUNC_START, 24'sd0, 24'sd8000000, 24'sd1000, -24'sd8000000,
                              1'b0, 1'b0}, 1'b0, '0});
        dir_tab.push_back('{random_next_item(), 1'b0, '0});
        dir_tab.push_back('{random_next_item(), 1'b0, '0});

        foreach (dir_tab[i]) begin
            offer_item(dir_tab[i].item, dir_tab[i].known, dir_tab[i].want);
        end
        n_dir = items_sent;

        // pause the sender until the block is empty
        wait_all_results();

        // random part: mostly complete shapes, plus noise and cut-short shapes
        while (items_sent - n_dir < N_RANDOM) begin
            if (items_sent - n_dir > (N_RANDOM * 9) / 10) begin
                calm = 1'b1;
            end
            if (hold_asked == 0 && items_sent - n_dir > 200) begin
                hold_asked = 1;
            end
            pick = $urandom_range(99, 0);
            if (pick < 75) begin
                // well-formed shape: random vertex, mostly small x span
                ox   = longint'($signed(CW'($urandom)));
                oy   = longint'($signed(CW'($urandom)));
                pick = $urandom_range(99, 0);
                if (pick < 80) begin
                    dx = $urandom_range(6143, 0);
                end
                else if (pick < 97) begin
                    dx = $urandom_range(128 * 200, 6144);
                end
                else begin
                    dx = $urandom_range(600000, 0);
                end
                if ($urandom_range(1, 0) == 1) begin
                    dx = -dx;
                end
                pick = $urandom_range(99, 0);
                if (pick < 40) begin
                    dy = longint'($urandom_range(20000, 0)) - 10000;
                end
                else if (pick < 80) begin
                    dy = longint'($signed(CW'($urandom)));
                end
                else begin
                    dy = ($urandom_range(1, 0) == 1) ? C_HI : C_LO;
                end
                it.func        = FUNC_START;
                it.origin_x    = CW'(ox);
                it.origin_y    = CW'(oy);
                it.end_x       = CW'(clamp24(ox + dx));
                it.end_y       = CW'(clamp24(oy + dy));
                it.shift_key   = 1'($urandom);
                it.control_key = 1'($urandom);
                offer_item(it, 1'b0, '0);
                // play the whole curve, or cut it short now and then
                pts = int'(shape_steps) + 1;
                if (shape_steps > 250) begin
                    pts = $urandom_range(40, 1);
                end
                else if ($urandom_range(7, 0) == 0) begin
                    pts = $urandom_range(int'(shape_steps), 1);
                end
                repeat (pts) offer_item(random_next_item(), 1'b0, '0);
            end
            else if (pick < 85) begin
                // stray next item, usually with no shape active
                offer_item(random_next_item(), 1'b0, '0);
            end
            else if (pick < 95) begin
                // wild start with any coordinates, then a few points
                it.func        = FUNC_START;
                it.origin_x    = CW'($urandom);
                it.origin_y    = CW'($urandom);
                it.end_x       = CW'($urandom);
                it.end_y       = CW'($urandom);
                it.shift_key   = 1'($urandom);
                it.control_key = 1'($urandom);
                offer_item(it, 1'b0, '0);
                repeat ($urandom_range(4, 0)) offer_item(random_next_item(), 1'b0, '0);
            end
            else begin
                wait_all_results();
            end
        end

        // drain, then give the block time to show any stray result
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d items: %0d shape summaries, %0d curve points,", items_sent,
                 n_summary, n_points);
        $display("%0d curves played to their final point, %0d answers with no shape active",
                 n_curves, n_none);
        if (errors == 0) begin
            $display("tb_polynomial_curve_point_generator: clean");
        end
        else begin
            $display("tb_polynomial_curve_point_generator: errors");
        end
        $finish;
    end

endmodule
